@@ hw/rtl/sfd_pkg.sv @@
// Shared types and constants of the stereo feedback delay.
// Holds sequencer states, product codes, register indexes and MAC control.
// No dependencies.
package sfd_pkg;

	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_IDX_BITS  = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_DELAY_LEFT    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DELAY_RIGHT   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK_GAIN = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIX_GAIN      = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_LOWPASS_COEFF = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_PING_PONG     = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_MONO_INPUT    = 3'd6;

	localparam int SMOOTH_FRAC   = 8;
	localparam int FEEDBACK_MAX  = 31130;
	localparam int UNITY_Q15     = 32768;
	localparam int OPB_BITS      = 17;
	localparam int RND_BIAS_Q15  = 1 << 14;
	localparam int RND_BIAS_Q23  = 1 << 22;
	localparam int SHIFT_Q15     = 15;
	localparam int SHIFT_Q23     = 23;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL,
		ST_WR,
		ST_FIN
	} sfd_state_t;

	// Product being formed; each takes two MAC steps (low half, high half).
	typedef enum logic [2:0] {
		PR_DIFF_L,
		PR_DIFF_R,
		PR_FB_L,
		PR_FB_R,
		PR_DRY_L,
		PR_WET_L,
		PR_DRY_R,
		PR_WET_R
	} sfd_prod_t;

	// Steps at which a finished accumulation is taken up.
	localparam logic [3:0] STEP_TAKE_SMOOTH_L = 4'd2;
	localparam logic [3:0] STEP_TAKE_SMOOTH_R = 4'd4;
	localparam logic [3:0] STEP_TAKE_FB_L     = 4'd6;
	localparam logic [3:0] STEP_TAKE_FB_R     = 4'd8;
	localparam logic [3:0] STEP_TAKE_MIX_L    = 4'd12;
	localparam logic [3:0] STEP_LAST          = 4'd15;

	typedef enum logic {
		RND_Q15,
		RND_Q23
	} sfd_rnd_t;

	typedef struct packed {
		logic     en;
		logic     clear;
		logic     hi;
		sfd_rnd_t rnd;
	} sfd_mac_ctl_t;

endpackage

@@ hw/rtl/sfd_if.sv @@
// Stream interfaces of the stereo feedback delay: input pair and output pair.
// Valid/ready handshake; a word moves when both are high at a rising edge.
// No dependencies.
interface sfd_in_if #(parameter int SAMPLE_BITS = 24) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sfd_out_if #(parameter int SAMPLE_BITS = 24) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

@@ hw/rtl/sfd_line.sv @@
// One channel of circular delay memory: one write port, one registered read port.
// Depends on nothing.
module sfd_line #(
	parameter int DEPTH       = 65536,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(DEPTH)-1:0]      waddr,
	input  logic signed [SAMPLE_BITS-1:0] wdata,
	input  logic                          re,
	input  logic [$clog2(DEPTH)-1:0]      raddr,
	output logic signed [SAMPLE_BITS-1:0] rdata
);

	logic signed [SAMPLE_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/sfd_mac.sv @@
// Shared multiply-accumulate unit: multiplies one half of a wide signed operand
// by a 17-bit signed gain per step and accumulates. Depends on sfd_pkg.
module sfd_mac #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                   clk,
	input  sfd_pkg::sfd_mac_ctl_t                  ctl,
	input  logic signed [SAMPLE_BITS+8:0]          a,
	input  logic signed [sfd_pkg::OPB_BITS-1:0]    b,
	output logic signed [SAMPLE_BITS+25:0]         acc_q
);
	import sfd_pkg::*;

	localparam int W     = SAMPLE_BITS + 9;
	localparam int HALF  = W / 2;
	localparam int PW    = HALF + 1;
	localparam int PRW   = PW + OPB_BITS;
	localparam int ACC_W = SAMPLE_BITS + 26;

	logic signed [PW-1:0]    part;
	logic signed [PRW-1:0]   prod;
	logic signed [ACC_W-1:0] prod_ext;
	logic signed [ACC_W-1:0] addend;
	logic signed [ACC_W-1:0] base;

	// Low half is unsigned, high half carries the sign.
	always_comb begin
		if (ctl.hi) begin
			part = PW'(a >>> HALF);
		end else begin
			part = $signed({1'b0, a[HALF-1:0]});
		end
	end

	assign prod     = part * b;
	assign prod_ext = ACC_W'(prod);
	assign addend   = ctl.hi ? (prod_ext <<< HALF) : prod_ext;

	// A fresh accumulation starts from the rounding bias.
	always_comb begin
		if (!ctl.clear) begin
			base = acc_q;
		end else if (ctl.rnd == RND_Q23) begin
			base = ACC_W'(RND_BIAS_Q23);
		end else begin
			base = ACC_W'(RND_BIAS_Q15);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= base + addend;
		end
	end

endmodule

@@ hw/rtl/stereo_feedback_delay_unit.sv @@
// Stereo feedback delay with a low-passed, optionally crossed feedback path.
// Instantiates sfd_line (twice) and sfd_mac; uses sfd_pkg and the sfd_if streams.
// Use:
//   in_ch   takes one stereo word (left_in, right_in) per handshake.
//   out_ch  gives one mixed stereo word (left_out, right_out) per input word.
//   cfg_*   plain register writes; write only while the block is idle.
// Sequence:
//   A word is worked in order from acceptance to the next possible acceptance:
//   both delay memories are read on acceptance, the filter differences are formed,
//   16 steps of the single shared multiply-accumulate unit follow (eight products,
//   each split into two half-width multiplies), both memories are written, and
//   the output register is loaded. The shared multiplier takes most of this work.
//   The result appears on out_ch once the output register is loaded. in_ch.ready is
//   high only while the sequencer is idle.
// Stalls:
//   The output register holds a finished word while the sink stalls; the next
//   word is still accepted and worked, then held at its last step until it frees.
// Reset:
//   Registers take their defaults; filter states and write pointer clear. Delay
//   memory is not cleared: a fill count makes unwritten entries read as zero.
module stereo_feedback_delay_unit #(
	parameter int LINE_DEPTH  = 65536,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [sfd_pkg::CFG_IDX_BITS-1:0]      cfg_idx,
	input  logic [sfd_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	sfd_in_if.sink                                in_ch,
	sfd_out_if.source                             out_ch
);
	import sfd_pkg::*;

	localparam int SB    = SAMPLE_BITS;
	localparam int SW    = SB + SMOOTH_FRAC;   // filter state width
	localparam int W     = SB + 9;             // MAC operand width
	localparam int ACC_W = SB + 26;
	localparam int AW    = $clog2(LINE_DEPTH);
	localparam int CW    = (AW > 16) ? AW : 16;

	// ---------------------------------------------------------------- config
	logic [15:0] delay_left_q;
	logic [15:0] delay_right_q;
	logic [14:0] feedback_gain_q;
	logic [15:0] mix_gain_q;
	logic [14:0] lowpass_coeff_q;
	logic        ping_pong_q;
	logic        mono_input_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_left_q    <= 16'd12000;
			delay_right_q   <= 16'd12000;
			feedback_gain_q <= 15'd13107;
			mix_gain_q      <= 16'd16384;
			lowpass_coeff_q <= 15'd16384;
			ping_pong_q     <= 1'b0;
			mono_input_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DELAY_LEFT:    delay_left_q    <= cfg_data;
				REG_DELAY_RIGHT:   delay_right_q   <= cfg_data;
				REG_FEEDBACK_GAIN: feedback_gain_q <= cfg_data[14:0];
				REG_MIX_GAIN:      mix_gain_q      <= cfg_data;
				REG_LOWPASS_COEFF: lowpass_coeff_q <= cfg_data[14:0];
				REG_PING_PONG:     ping_pong_q     <= cfg_data[0];
				REG_MONO_INPUT:    mono_input_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Clamped gains, as the gain operands of the MAC.
	logic [14:0] gain_fb;
	logic [15:0] gain_wet;
	logic [15:0] gain_dry;

	assign gain_fb  = (feedback_gain_q > 15'(FEEDBACK_MAX)) ? 15'(FEEDBACK_MAX)
		: feedback_gain_q;
	assign gain_wet = (mix_gain_q > 16'(UNITY_Q15)) ? 16'(UNITY_Q15) : mix_gain_q;
	assign gain_dry = 16'(UNITY_Q15 - int'(gain_wet));

	// ---------------------------------------------------------------- helpers
	function automatic logic [AW-1:0] clamp_delay(input logic [15:0] d);
		logic [CW-1:0] e;
		e = CW'(d);
		if (e == '0) begin
			return AW'(1);
		end else if (e > CW'(LINE_DEPTH - 1)) begin
			return AW'(LINE_DEPTH - 1);
		end else begin
			return AW'(e);
		end
	endfunction

	function automatic logic [AW-1:0] read_addr(input logic [AW-1:0] w,
		input logic [AW-1:0] dc);
		logic [AW:0] t;
		t = {1'b0, w} - {1'b0, dc};
		if (t[AW]) begin
			t = t + (AW+1)'(LINE_DEPTH);
		end
		return t[AW-1:0];
	endfunction

	function automatic logic signed [SB-1:0] sat(input logic signed [SB:0] v);
		if (v[SB] != v[SB-1]) begin
			return v[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
		end else begin
			return v[SB-1:0];
		end
	endfunction

	// ---------------------------------------------------------------- sequencer
	sfd_state_t  state_q, state_nxt;
	logic [3:0]  step_q;
	logic        accept;
	logic        take_sl, take_sr, take_fbl, take_fbr, take_mixl;
	logic        line_we, out_ld;
	sfd_mac_ctl_t mac_ctl;
	sfd_prod_t   prod_sel;

	assign prod_sel = sfd_prod_t'(step_q[3:1]);
	assign accept   = in_ch.valid && in_ch.ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) state_nxt = ST_DIFF;
			end
			ST_DIFF: state_nxt = ST_MUL;
			ST_MUL: begin
				if (step_q == STEP_LAST) state_nxt = ST_WR;
			end
			ST_WR: state_nxt = ST_FIN;
			ST_FIN: begin
				if (!out_ch.valid || out_ch.ready) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready   = (state_q == ST_IDLE);
		mac_ctl.en    = (state_q == ST_MUL);
		mac_ctl.hi    = step_q[0];
		// Wet products add onto the dry product already in the accumulator.
		mac_ctl.clear = !step_q[0] && (prod_sel != PR_WET_L) && (prod_sel != PR_WET_R);
		mac_ctl.rnd   = ((prod_sel == PR_FB_L) || (prod_sel == PR_FB_R)) ? RND_Q23
			: RND_Q15;
		take_sl       = (state_q == ST_MUL) && (step_q == STEP_TAKE_SMOOTH_L);
		take_sr       = (state_q == ST_MUL) && (step_q == STEP_TAKE_SMOOTH_R);
		take_fbl      = (state_q == ST_MUL) && (step_q == STEP_TAKE_FB_L);
		take_fbr      = (state_q == ST_MUL) && (step_q == STEP_TAKE_FB_R);
		take_mixl     = (state_q == ST_MUL) && (step_q == STEP_TAKE_MIX_L);
		line_we       = (state_q == ST_WR);
		out_ld        = (state_q == ST_FIN) && (!out_ch.valid || out_ch.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_MUL) begin
				step_q <= step_q + 4'd1;
			end
		end
	end

	// ---------------------------------------------------------------- delay lines
	logic [AW-1:0]        w_q;
	logic [AW-1:0]        fill_q;     // written entries, saturating at LINE_DEPTH-1
	logic [AW-1:0]        dcl, dcr;
	logic signed [SB-1:0] rdl, rdr;
	logic                 vl_q, vr_q;
	logic signed [SB-1:0] wdl, wdr;
	logic signed [SB-1:0] fbl_q, fbr_q;
	logic signed [SB-1:0] inl_q, inr_q;

	assign dcl = clamp_delay(delay_left_q);
	assign dcr = clamp_delay(delay_right_q);

	// Cross the echoes in ping-pong mode.
	assign wdl = sat((SB+1)'(inl_q) + (SB+1)'(ping_pong_q ? fbr_q : fbl_q));
	assign wdr = sat((SB+1)'(inr_q) + (SB+1)'(ping_pong_q ? fbl_q : fbr_q));

	sfd_line #(.DEPTH(LINE_DEPTH), .SAMPLE_BITS(SB)) u_line_l (
		.clk   (clk),
		.we    (line_we),
		.waddr (w_q),
		.wdata (wdl),
		.re    (accept),
		.raddr (read_addr(w_q, dcl)),
		.rdata (rdl)
	);

	sfd_line #(.DEPTH(LINE_DEPTH), .SAMPLE_BITS(SB)) u_line_r (
		.clk   (clk),
		.we    (line_we),
		.waddr (w_q),
		.wdata (wdr),
		.re    (accept),
		.raddr (read_addr(w_q, dcr)),
		.rdata (rdr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= '0;
			fill_q <= '0;
		end else if (line_we) begin
			w_q <= (w_q == AW'(LINE_DEPTH - 1)) ? '0 : w_q + AW'(1);
			if (fill_q != AW'(LINE_DEPTH - 1)) begin
				fill_q <= fill_q + AW'(1);
			end
		end
	end

	// Latch the input pair and whether each tap has been written yet.
	always_ff @(posedge clk) begin
		if (accept) begin
			inl_q <= in_ch.left_in;
			inr_q <= mono_input_q ? in_ch.left_in : in_ch.right_in;
			vl_q  <= (fill_q >= dcl);
			vr_q  <= (fill_q >= dcr);
		end
	end

	// ---------------------------------------------------------------- datapath
	logic signed [SB-1:0]    dl_q, dr_q;
	logic signed [W-1:0]     diffl_q, diffr_q;
	logic signed [SW-1:0]    sl_q, sr_q;
	logic signed [SB-1:0]    resl_q;
	logic signed [SB-1:0]    outl_q, outr_q;
	logic                    ovalid_q;
	logic signed [W-1:0]     mac_a;
	logic signed [OPB_BITS-1:0] mac_b;
	logic signed [ACC_W-1:0] acc;
	logic signed [SW:0]      smooth_delta;
	logic signed [SB-1:0]    acc_fb;
	logic signed [SB-1:0]    acc_mix;
	logic signed [SB-1:0]    tap_l, tap_r;

	// Unwritten taps read as zero.
	assign tap_l = vl_q ? rdl : '0;
	assign tap_r = vr_q ? rdr : '0;

	always_ff @(posedge clk) begin
		if (state_q == ST_DIFF) begin
			dl_q    <= tap_l;
			dr_q    <= tap_r;
			diffl_q <= (W'(tap_l) <<< SMOOTH_FRAC) - W'(sl_q);
			diffr_q <= (W'(tap_r) <<< SMOOTH_FRAC) - W'(sr_q);
		end
	end

	always_comb begin
		case (prod_sel)
			PR_DIFF_L: mac_a = diffl_q;
			PR_DIFF_R: mac_a = diffr_q;
			PR_FB_L:   mac_a = W'(sl_q);
			PR_FB_R:   mac_a = W'(sr_q);
			PR_DRY_L:  mac_a = W'(inl_q);
			PR_WET_L:  mac_a = W'(dl_q);
			PR_DRY_R:  mac_a = W'(inr_q);
			PR_WET_R:  mac_a = W'(dr_q);
			default:   mac_a = '0;
		endcase
	end

	always_comb begin
		case (prod_sel)
			PR_DIFF_L, PR_DIFF_R: mac_b = $signed({2'b00, lowpass_coeff_q});
			PR_FB_L, PR_FB_R:     mac_b = $signed({2'b00, gain_fb});
			PR_DRY_L, PR_DRY_R:   mac_b = $signed({1'b0, gain_dry});
			PR_WET_L, PR_WET_R:   mac_b = $signed({1'b0, gain_wet});
			default:              mac_b = '0;
		endcase
	end

	sfd_mac #(.SAMPLE_BITS(SB)) u_mac (
		.clk   (clk),
		.ctl   (mac_ctl),
		.a     (mac_a),
		.b     (mac_b),
		.acc_q (acc)
	);

	// Rounded results: the bias was loaded when the accumulation began.
	assign smooth_delta = $signed(acc[SHIFT_Q15 +: SW+1]);
	assign acc_fb       = $signed(acc[SHIFT_Q23 +: SB]);
	assign acc_mix      = sat($signed(acc[SHIFT_Q15 +: SB+1]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sl_q <= '0;
			sr_q <= '0;
		end else begin
			if (take_sl) sl_q <= SW'((SW+1)'(sl_q) + smooth_delta);
			if (take_sr) sr_q <= SW'((SW+1)'(sr_q) + smooth_delta);
		end
	end

	always_ff @(posedge clk) begin
		if (take_fbl)  fbl_q  <= acc_fb;
		if (take_fbr)  fbr_q  <= acc_fb;
		if (take_mixl) resl_q <= acc_mix;
		if (line_we)   outr_q <= acc_mix;
		if (out_ld)    outl_q <= resl_q;
	end

	// Output register: hold the word until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_ld) begin
			ovalid_q <= 1'b1;
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	logic signed [SB-1:0] right_hold_q;

	always_ff @(posedge clk) begin
		if (out_ld) right_hold_q <= outr_q;
	end

	assign out_ch.valid     = ovalid_q;
	assign out_ch.left_out  = outl_q;
	assign out_ch.right_out = right_hold_q;

	// ---------------------------------------------------------------- checks
	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_MUL) |-> (step_q == '0))
		else $error("step counter moved outside the multiply phase");

	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && ovalid_q && !out_ch.ready) |=> (state_q == ST_FIN))
		else $error("finished word left while output register was full");

	a_wptr_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |=> (w_q != $past(w_q)))
		else $error("write pointer did not advance after a memory write");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> ($past(state_q) == ST_FIN))
		else $error("output word raised outside the final step");

endmodule

@@ dv/stereo_feedback_delay_checker.sv @@
`timescale 1ns / 100ps
// Output checker for the stereo feedback delay: keeps its own delay lines,
// filter states and register copies, and compares every mixed output word.
// Depends on sfd_pkg and the sfd_in_if / sfd_out_if stream interfaces.
module stereo_feedback_delay_checker #(
	parameter int LINE_DEPTH  = 65536,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sfd_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [sfd_pkg::CFG_DATA_BITS-1:0] cfg_data,
	sfd_in_if                                 in_ch,
	sfd_out_if                                out_ch,
	output int                                mismatches,
	output int                                pending
);
	import sfd_pkg::*;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef struct packed {
		sample_t left;
		sample_t right;
	} stereo_t;

	localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_LO = -SAMPLE_HI - 1;

	// two-state lines start at zero, which is their reset contents
	bit signed [SAMPLE_BITS-1:0] left_line  [LINE_DEPTH];
	bit signed [SAMPLE_BITS-1:0] right_line [LINE_DEPTH];
	int unsigned                 wr_pos;
	longint                      left_lp;
	longint                      right_lp;

	logic [15:0] dly_left;
	logic [15:0] dly_right;
	logic [14:0] fb_gain;
	logic [15:0] wet_gain;
	logic [14:0] lp_coeff;
	logic        cross_fb;
	logic        mono;

	stereo_t mix_q[$];
	int      err_cnt;

	// round to nearest, ties upward
	function automatic longint round_sh(longint v, int sh);
		return (v + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint clip(longint v);
		if (v > SAMPLE_HI)
			return SAMPLE_HI;
		if (v < SAMPLE_LO)
			return SAMPLE_LO;
		return v;
	endfunction

	function automatic int unsigned tap(logic [15:0] d);
		int unsigned k;
		k = d;
		if (k < 1)
			k = 1;
		if (k > LINE_DEPTH - 1)
			k = LINE_DEPTH - 1;
		return (wr_pos + LINE_DEPTH - k) % LINE_DEPTH;
	endfunction

	function automatic longint lp_step(longint s, longint d);
		return s + round_sh(((d <<< SMOOTH_FRAC) - s) * longint'(lp_coeff), SHIFT_Q15);
	endfunction

	function automatic sample_t dry_wet(longint dry, longint wet);
		longint m;
		m = wet_gain;
		if (m > UNITY_Q15)
			m = UNITY_Q15;
		return sample_t'(clip(round_sh(dry * (UNITY_Q15 - m) + wet * m, SHIFT_Q15)));
	endfunction

	// advance the lines and filters by one word and give the mixed pair
	function automatic stereo_t predict_mix(sample_t l_in, sample_t r_in);
		longint  in_l, in_r, d_l, d_r, fb_l, fb_r, g;
		stereo_t res;
		in_l = l_in;
		in_r = mono ? in_l : longint'(r_in);
		d_l = left_line[tap(dly_left)];
		d_r = right_line[tap(dly_right)];
		left_lp  = lp_step(left_lp, d_l);
		right_lp = lp_step(right_lp, d_r);
		g = fb_gain;
		if (g > FEEDBACK_MAX)
			g = FEEDBACK_MAX;
		fb_l = round_sh(left_lp * g, SHIFT_Q23);
		fb_r = round_sh(right_lp * g, SHIFT_Q23);
		if (cross_fb) begin
			left_line[wr_pos]  = sample_t'(clip(in_l + fb_r));
			right_line[wr_pos] = sample_t'(clip(in_r + fb_l));
		end else begin
			left_line[wr_pos]  = sample_t'(clip(in_l + fb_l));
			right_line[wr_pos] = sample_t'(clip(in_r + fb_r));
		end
		wr_pos = (wr_pos + 1) % LINE_DEPTH;
		res.left  = dry_wet(in_l, d_l);
		res.right = dry_wet(in_r, d_r);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stereo_t want;
		if (!arst_n) begin
			dly_left  = 16'd12000;
			dly_right = 16'd12000;
			fb_gain   = 15'd13107;
			wet_gain  = 16'd16384;
			lp_coeff  = 15'd16384;
			cross_fb  = 1'b0;
			mono      = 1'b0;
			wr_pos    = 0;
			left_lp   = 0;
			right_lp  = 0;
			mix_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_DELAY_LEFT:    dly_left  = cfg_data;
					REG_DELAY_RIGHT:   dly_right = cfg_data;
					REG_FEEDBACK_GAIN: fb_gain   = cfg_data[14:0];
					REG_MIX_GAIN:      wet_gain  = cfg_data;
					REG_LOWPASS_COEFF: lp_coeff  = cfg_data[14:0];
					REG_PING_PONG:     cross_fb  = cfg_data[0];
					REG_MONO_INPUT:    mono      = cfg_data[0];
					default: ;
				endcase
			end
			// outputs first: a word accepted now cannot have its result out yet
			if (out_ch.valid && out_ch.ready) begin
				if (mix_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("%0t: unexpected output word L=%0d R=%0d",
							$realtime, out_ch.left_out, out_ch.right_out);
				end else begin
					want = mix_q.pop_front();
					if (out_ch.left_out !== want.left || out_ch.right_out !== want.right) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("%0t: mix mismatch L exp %0d got %0d, R exp %0d got %0d",
								$realtime, want.left, out_ch.left_out,
								want.right, out_ch.right_out);
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				mix_q.push_back(predict_mix(in_ch.left_in, in_ch.right_in));
		end
		mismatches <= err_cnt;
		pending    <= mix_q.size();
	end

endmodule

@@ dv/stereo_feedback_delay_unit_tb.sv @@
`timescale 1ns / 100ps
// Top of the stereo feedback delay testbench: clock, reset, register writes,
// input stimulus, output back-pressure, watchdog and verdict.
// Depends on sfd_pkg, the sfd_if streams, the block and the output checker.
module stereo_feedback_delay_unit_tb;
	import sfd_pkg::*;

	localparam int LINE_DEPTH     = 65536;
	localparam int SAMPLE_BITS    = 24;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_WORDS    = 100;
	// long receiver hold-off: far beyond the two words the block can keep
	localparam int HOLD_CYCLES    = 400;
	// this leaves room for a word's processing, the hold-off and the longest
	// random gaps on either side
	localparam int WATCHDOG_LIMIT = 4000;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	localparam sample_t SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_idx;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	sfd_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
	sfd_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

	int mismatches;
	int pending;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles = 0;
	bit hold_req     = 1'b0;

	always #2 clk = ~clk;

	stereo_feedback_delay_unit #(
		.LINE_DEPTH (LINE_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	stereo_feedback_delay_checker #(
		.LINE_DEPTH (LINE_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mix_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.mismatches(mismatches),
		.pending   (pending)
	);

	// Receiver: stall at random, or hold off for a long stretch whenever
	// the stimulus flips hold_req. The hold-off is counted here, so the
	// sender keeps offering words and the block fills up behind it.
	initial begin
		bit hold_seen;
		int hold_left;
		hold_seen = 1'b0;
		hold_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: end the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("stereo_feedback_delay_unit_tb: FAIL");
				$finish;
			end
		end
	end

	// One register write; the block and the checker both take it at the
	// edge on which the task drops cfg_we again.
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
	                         input logic [CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	task automatic apply_settings(input logic [15:0] dl, input logic [15:0] dr,
	                              input logic [15:0] fb, input logic [15:0] mix,
	                              input logic [15:0] lp, input logic pp,
	                              input logic mo);
		write_reg(REG_DELAY_LEFT, dl);
		write_reg(REG_DELAY_RIGHT, dr);
		write_reg(REG_FEEDBACK_GAIN, fb);
		write_reg(REG_MIX_GAIN, mix);
		write_reg(REG_LOWPASS_COEFF, lp);
		write_reg(REG_PING_PONG, {15'd0, pp});
		write_reg(REG_MONO_INPUT, {15'd0, mo});
	endtask

	// Offer one stereo word, after a random gap, and return at the edge where it is
	// taken. Valid stays high so, unless a random gap comes first, the next word follows at once.
	task automatic send_word(input sample_t l, input sample_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.left_in  <= l;
		in_ch.right_in <= r;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// Drop valid and wait until every predicted word has come out. The first
	// edge lets the checker count a word taken at the current edge.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Mostly short delays so the echoes come round within a phase; now and
	// then zero, the longest delay, or anything, which reads unwritten slots.
	function automatic logic [15:0] pick_delay();
		case ($urandom_range(9))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(65535));
			default: return 16'($urandom_range(48, 1));
		endcase
	endfunction

	task automatic random_settings();
		logic [15:0] dl, dr, fb, mix, lp;
		dl = pick_delay();
		dr = pick_delay();
		case ($urandom_range(5))
			0:       fb = 16'($urandom_range(65535, 31131));
			1:       fb = 16'd31130;
			default: fb = 16'($urandom_range(31130));
		endcase
		case ($urandom_range(5))
			0:       mix = 16'd0;
			1:       mix = 16'd32768;
			2:       mix = 16'($urandom_range(65535, 32769));
			default: mix = 16'($urandom_range(32768));
		endcase
		case ($urandom_range(4))
			0:       lp = 16'd0;
			1:       lp = 16'd32767;
			default: lp = 16'($urandom_range(65535));
		endcase
		apply_settings(dl, dr, fb, mix, lp, 1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	// Full-scale noise most of the time, with rails and quiet signal mixed in
	// so the feedback both saturates and settles.
	function automatic sample_t pick_sample();
		case ($urandom_range(7))
			0:       return SMAX;
			1:       return SMIN;
			2:       return sample_t'(int'($urandom_range(2000)) - 1000);
			default: return sample_t'($urandom());
		endcase
	endfunction

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_idx        = REG_DELAY_LEFT;
		cfg_data       = '0;
		in_ch.valid    = 1'b0;
		in_ch.left_in  = '0;
		in_ch.right_in = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Register defaults: long delays, so both lines read never-written slots.
		send_word(SMAX, SMIN);
		send_word(SMIN, SMAX);
		send_word('0, '0);
		drain();

		// Zero delay taken as one, gain and mix above their limits, filter
		// coefficient at its top: rails feed straight back.
		apply_settings(16'd0, 16'd1, 16'd32767, 16'hFFFF, 16'd32767, 1'b0, 1'b0);
		send_word(SMAX, SMAX);
		send_word(SMAX, SMIN);
		send_word(SMIN, SMIN);
		send_word(SMIN, SMAX);
		send_word(SMAX, '0);
		send_word('0, SMIN);
		drain();

		// Crossed feedback, mono input, fully dry mix, frozen filter.
		apply_settings(16'd2, 16'd3, 16'd31130, 16'd0, 16'd0, 1'b1, 1'b1);
		send_word(SMAX, SMIN);
		send_word(SMIN, SMAX);
		send_word(sample_t'(1), SMAX);
		send_word(sample_t'(-1), '0);
		send_word(SMAX, SMAX);
		drain();

		// Longest delay, no feedback, fully wet, smallest filter step.
		apply_settings(16'hFFFF, 16'hFFFF, 16'd0, 16'd32768, 16'd1, 1'b1, 1'b0);
		send_word(SMAX, SMIN);
		send_word(SMIN, SMAX);
		send_word(sample_t'(-1), sample_t'(1));
		send_word('0, '0);
		drain();

		// Gain and mix just over their limits, mono, straight feedback.
		apply_settings(16'd1, 16'd2, 16'd31131, 16'd32769, 16'd16384, 1'b0, 1'b1);
		send_word(SMAX, SMIN);
		send_word(SMIN, SMAX);
		send_word(SMAX, sample_t'(1));
		send_word(sample_t'(1), SMIN);
		send_word(SMIN, sample_t'(-1));
		send_word(sample_t'(-1), SMAX);
		drain();

		// Random phases, each with its own settings and idling pattern.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			random_settings();
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
				default: begin send_idle_pct = 31; recv_stall_pct = 31; end
			endcase
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// hold the receiver off while words keep coming
				if (ph == 0 && n == 40)
					hold_req <= ~hold_req;
				// pause the sender until the block is empty, mid-stream
				if (ph == 5 && n == 50)
					drain();
				send_word(pick_sample(), pick_sample());
			end
		end

		drain();
		repeat (25) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("stereo_feedback_delay_unit_tb: PASS");
		end else begin
			$display("stereo_feedback_delay_unit_tb: FAIL");
		end
		$finish;
	end

endmodule
